// ===== hw/rtl/msrs_pkg.sv =====
// ----------------------------------------------------------------------------
// msrs_pkg
// Shared types, codes and widths of the multi-rate sensor read scheduler.
// ----------------------------------------------------------------------------
package msrs_pkg;

    localparam int CNT_W   = 16;
    localparam int PER_W   = 16;
    localparam int CMP_W   = (CNT_W > PER_W) ? CNT_W : PER_W;
    localparam int MODE_W  = 2;
    localparam int PHASE_W = 3;
    localparam int KIND_W  = 2;
    localparam int NKIND   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef logic [MODE_W-1:0]  t_mode;
    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [PER_W-1:0]   t_per;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_mode MODE_TICK        = 2'd0;
    localparam t_mode MODE_MOTOR_DONE  = 2'd1;
    localparam t_mode MODE_POWER_DONE  = 2'd2;
    localparam t_mode MODE_DEPTH_READY = 2'd3;

    localparam t_phase PH_READY      = 3'd0;
    localparam t_phase PH_DEPTH_CONV = 3'd1;
    localparam t_phase PH_TEMP_CONV  = 3'd2;
    localparam t_phase PH_DEPTH_READ = 3'd3;
    localparam t_phase PH_TEMP_READ  = 3'd4;

    localparam t_kind KIND_CMD   = 2'd0;
    localparam t_kind KIND_DEPTH = 2'd1;
    localparam t_kind KIND_MOTOR = 2'd2;
    localparam t_kind KIND_POWER = 2'd3;

    localparam t_cfg_idx CFG_DEPTH_PERIOD = 2'd0;
    localparam t_cfg_idx CFG_MOTOR_PERIOD = 2'd1;
    localparam t_cfg_idx CFG_POWER_PERIOD = 2'd2;
    localparam t_cfg_idx CFG_DEPTH_EN     = 2'd3;

    localparam t_per DEPTH_PERIOD_RST = 16'd8;
    localparam t_per MOTOR_PERIOD_RST = 16'd30;
    localparam t_per POWER_PERIOD_RST = 16'd120;

    // one tick's worth of results, bit index equals result kind
    typedef struct packed {
        logic [NKIND-1:0] mask;
        t_phase           phase;
        logic             lost;
    } t_evt;

endpackage

// ===== hw/rtl/msrs_req_if.sv =====
// ----------------------------------------------------------------------------
// msrs_req_if
// Request channel into the scheduler: mode, I2C phase and transmit ack.
// ----------------------------------------------------------------------------
interface msrs_req_if;
    import msrs_pkg::*;

    logic   valid;
    logic   ready;
    t_mode  mode;
    t_phase i2c_phase_in;
    logic   i2c_ack;

    modport source (output valid, mode, i2c_phase_in, i2c_ack, input ready);
    modport sink   (input valid, mode, i2c_phase_in, i2c_ack, output ready);
endinterface

// ===== hw/rtl/msrs_res_if.sv =====
// ----------------------------------------------------------------------------
// msrs_res_if
// Result channel out of the scheduler: one event per transfer.
// ----------------------------------------------------------------------------
interface msrs_res_if;
    import msrs_pkg::*;

    logic   valid;
    logic   ready;
    t_kind  kind;
    t_phase i2c_phase_out;
    logic   sensor_lost;
    logic   last;

    modport source (output valid, kind, i2c_phase_out, sensor_lost, last, input ready);
    modport sink   (input valid, kind, i2c_phase_out, sensor_lost, last, output ready);
endinterface

// ===== hw/rtl/msrs_front.sv =====
// ----------------------------------------------------------------------------
// msrs_front
// Accepts requests, keeps config, counters and flags, builds the event mask.
// ----------------------------------------------------------------------------
module msrs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  msrs_pkg::t_cfg_idx i_cfg_idx,
    input  logic [msrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    msrs_req_if.sink           i_req,
    input  logic               i_q_full,
    output logic               o_push,
    output msrs_pkg::t_evt     o_evt
);
    import msrs_pkg::*;

    localparam t_cnt CNT_MAX = '1;

    t_per r_depth_per, r_motor_per, r_power_per;
    logic r_depth_en;
    t_cnt r_depth_cnt, r_motor_cnt, r_power_cnt;
    t_cnt n_depth_cnt, n_motor_cnt, n_power_cnt;
    logic r_motor_idle, r_power_idle, r_pend;
    logic n_motor_idle, n_power_idle, n_pend;
    logic accept;
    t_cnt d_bump, m_bump, p_bump;
    t_phase ph;

    function automatic t_cnt bump(input t_cnt c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic reached(input t_cnt c, input t_per p);
        return CMP_W'(c) >= CMP_W'(p);
    endfunction

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && !i_q_full;
    assign d_bump      = bump(r_depth_cnt);
    assign m_bump      = bump(r_motor_cnt);
    assign p_bump      = bump(r_power_cnt);

    always_comb begin
        n_depth_cnt  = r_depth_cnt;
        n_motor_cnt  = r_motor_cnt;
        n_power_cnt  = r_power_cnt;
        n_motor_idle = r_motor_idle;
        n_power_idle = r_power_idle;
        n_pend       = r_pend;
        o_evt        = '0;
        o_push       = 1'b0;
        ph           = i_req.i2c_phase_in;
        if (ph == PH_DEPTH_CONV) begin
            ph = PH_DEPTH_READ;
        end else if (ph == PH_TEMP_CONV) begin
            ph = PH_TEMP_READ;
        end
        if (accept) begin
            case (i_req.mode)
                MODE_MOTOR_DONE:  n_motor_idle = 1'b1;
                MODE_POWER_DONE:  n_power_idle = 1'b1;
                MODE_DEPTH_READY: n_pend = 1'b1;
                MODE_TICK: begin
                    if (r_pend) begin
                        o_evt.mask[KIND_CMD] = 1'b1;
                        o_evt.phase = i_req.i2c_ack ? ph : PH_READY;
                        o_evt.lost  = !i_req.i2c_ack;
                        n_pend = 1'b0;
                    end
                    if (r_depth_en) begin
                        n_depth_cnt = d_bump;
                        if (reached(d_bump, r_depth_per)) begin
                            o_evt.mask[KIND_DEPTH] = 1'b1;
                            n_depth_cnt = '0;
                        end
                    end
                    n_motor_cnt = m_bump;
                    if (reached(m_bump, r_motor_per) && r_motor_idle) begin
                        o_evt.mask[KIND_MOTOR] = 1'b1;
                        n_motor_cnt  = '0;
                        n_motor_idle = 1'b0;
                    end
                    n_power_cnt = p_bump;
                    if (reached(p_bump, r_power_per) && r_power_idle) begin
                        o_evt.mask[KIND_POWER] = 1'b1;
                        n_power_cnt  = '0;
                        n_power_idle = 1'b0;
                    end
                    o_push = (o_evt.mask != '0);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_per  <= DEPTH_PERIOD_RST;
            r_motor_per  <= MOTOR_PERIOD_RST;
            r_power_per  <= POWER_PERIOD_RST;
            r_depth_en   <= 1'b1;
            r_depth_cnt  <= '0;
            r_motor_cnt  <= '0;
            r_power_cnt  <= '0;
            r_motor_idle <= 1'b1;
            r_power_idle <= 1'b1;
            r_pend       <= 1'b0;
        end else begin
            r_depth_cnt  <= n_depth_cnt;
            r_motor_cnt  <= n_motor_cnt;
            r_power_cnt  <= n_power_cnt;
            r_motor_idle <= n_motor_idle;
            r_power_idle <= n_power_idle;
            r_pend       <= n_pend;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEPTH_PERIOD: r_depth_per <= PER_W'(i_cfg_data);
                    CFG_MOTOR_PERIOD: r_motor_per <= PER_W'(i_cfg_data);
                    CFG_POWER_PERIOD: r_power_per <= PER_W'(i_cfg_data);
                    CFG_DEPTH_EN:     r_depth_en  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== hw/rtl/msrs_queue.sv =====
// ----------------------------------------------------------------------------
// msrs_queue
// Short FIFO of per-tick event records between front and back.
// ----------------------------------------------------------------------------
module msrs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  msrs_pkg::t_evt i_evt,
    input  logic           i_pop,
    output msrs_pkg::t_evt o_head,
    output logic           o_empty,
    output logic           o_full
);
    import msrs_pkg::*;

    t_evt              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ===== hw/rtl/msrs_back.sv =====
// ----------------------------------------------------------------------------
// msrs_back
// Serializes each record into registered results, one per cycle while ready.
// ----------------------------------------------------------------------------
module msrs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  msrs_pkg::t_evt i_head,
    input  logic           i_empty,
    output logic           o_pop,
    msrs_res_if.source     o_res
);
    import msrs_pkg::*;

    logic             r_valid, r_lost, r_last;
    t_kind            r_kind;
    t_phase           r_phase;
    logic [NKIND-1:0] r_rem;
    logic             load, use_rem, have;
    logic [NKIND-1:0] src, low, rest;
    t_kind            k;

    assign load    = !r_valid || o_res.ready;
    assign use_rem = (r_rem != '0);
    assign src     = use_rem ? r_rem : i_head.mask;
    assign have    = use_rem || !i_empty;
    assign o_pop   = load && !use_rem && !i_empty;
    assign rest    = src & ~low;

    always_comb begin
        k   = KIND_CMD;
        low = '0;
        for (int i = NKIND - 1; i >= 0; i--) begin
            if (src[i]) begin
                k   = KIND_W'(i);
                low = '0;
                low[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rem   <= '0;
        end else if (load) begin
            r_valid <= have;
            if (have) begin
                r_rem <= rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && have) begin
            r_kind  <= k;
            r_last  <= (rest == '0);
            r_phase <= (k == KIND_CMD) ? i_head.phase : PH_READY;
            r_lost  <= (k == KIND_CMD) ? i_head.lost : 1'b0;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.kind          = r_kind;
    assign o_res.i2c_phase_out = r_phase;
    assign o_res.sensor_lost   = r_lost;
    assign o_res.last          = r_last;
endmodule

// ===== hw/rtl/multi_rate_sensor_read_scheduler.sv =====
// ----------------------------------------------------------------------------
// multi_rate_sensor_read_scheduler
// Tick-driven scheduler of depth, motor and power sensor read requests.
//
//   channel  dir  carries                                 handshake
//   i_req    in   mode, i2c_phase_in, i2c_ack             valid / ready
//   o_res    out  kind, i2c_phase_out, sensor_lost, last  valid / ready
//   i_cfg_*  in   register index, write data              write enable only
//
// a request is taken every cycle while the two-entry event queue has room
// a tick yields zero to four results, sent one per cycle from the back end
// while the output port is ready, so the output port paces the results of a tick
// non-tick requests and ticks without results finish in the cycle they enter
// reset is synchronous, active low, and restores the register defaults
// ----------------------------------------------------------------------------
module multi_rate_sensor_read_scheduler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  msrs_pkg::t_cfg_idx i_cfg_idx,
    input  logic [msrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    msrs_req_if.sink           i_req,
    msrs_res_if.source         o_res
);
    import msrs_pkg::*;

    logic push, pop, q_empty, q_full;
    t_evt evt, head;

    msrs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_evt      (evt)
    );

    msrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (evt),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    msrs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );
endmodule

// ===== hw/rtl/msrs_checker.sv =====
// ----------------------------------------------------------------------------
// msrs_checker
// Port-level checks on the result channel of the scheduler.
// ----------------------------------------------------------------------------
module msrs_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 i_ready,
    input msrs_pkg::t_kind      i_kind,
    input msrs_pkg::t_phase     i_phase,
    input logic                 i_lost,
    input logic                 i_last
);
    import msrs_pkg::*;

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_kind) && $stable(i_last))
        else $error("result changed while stalled");

    a_request_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind != KIND_CMD) |-> (i_phase == PH_READY) && !i_lost)
        else $error("request result carries phase or lost flag");

    a_lost_phase_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == KIND_CMD) && i_lost |-> (i_phase == PH_READY))
        else $error("lost sensor without phase back to ready");
endmodule

bind multi_rate_sensor_read_scheduler msrs_checker u_msrs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_kind  (o_res.kind),
    .i_phase (o_res.i2c_phase_out),
    .i_lost  (o_res.sensor_lost),
    .i_last  (o_res.last)
);
